@@ rtl/arm_lba_pkg.sv @@
// Package for the logical and bitfield execute unit.
// Holds opcode, shift and condition codes, item and result types.
// Used by every module of the block; depends on nothing.
`default_nettype none

package arm_lba_pkg;

  localparam int unsigned XLEN       = 32;
  localparam int unsigned FLAGS_W    = 4;
  localparam int unsigned IN_DATA_W  = 128;
  localparam int unsigned OUT_DATA_W = 72;

  typedef enum logic [3:0] {
    OP_AND  = 4'd0,
    OP_ORR  = 4'd1,
    OP_EOR  = 4'd2,
    OP_BIC  = 4'd3,
    OP_TST  = 4'd4,
    OP_BFC  = 4'd5,
    OP_UXTB = 4'd6,
    OP_UXTH = 4'd7,
    OP_SXTB = 4'd8,
    OP_SXTH = 4'd9,
    OP_CLZ  = 4'd10
  } op_e;

  typedef enum logic [2:0] {
    SH_LSL = 3'd0,
    SH_LSR = 3'd1,
    SH_ASR = 3'd2,
    SH_ROR = 3'd3,
    SH_RRX = 3'd4
  } shift_e;

  typedef enum logic [2:0] {
    CG_EQ = 3'd0,
    CG_CS = 3'd1,
    CG_MI = 3'd2,
    CG_VS = 3'd3,
    CG_HI = 3'd4,
    CG_GE = 3'd5,
    CG_GT = 3'd6,
    CG_AL = 3'd7
  } cond_grp_e;

  localparam logic [XLEN-1:0] BYTE_MASK = 32'h0000_00FF;
  localparam logic [XLEN-1:0] HALF_MASK = 32'h0000_FFFF;
  localparam logic [XLEN-1:0] ALL_ONES  = 32'hFFFF_FFFF;
  localparam logic [XLEN-1:0] PC_STEP   = 32'd4;

  typedef struct packed {
    logic [3:0]      opcode;
    logic [3:0]      cond;
    logic [XLEN-1:0] pc_value;
    logic [XLEN-1:0] rn_value;
    logic [XLEN-1:0] operand_value;
    logic [2:0]      shift_kind;
    logic [5:0]      shift_amount;
    logic            carry_in;
    logic            set_flags;
    logic            dest_is_pc;
    logic [4:0]      field_msb;
    logic [4:0]      field_lsb;
  } item_t;

  typedef struct packed {
    logic               executed;
    logic [XLEN-1:0]    result_value;
    logic               reg_write;
    logic [XLEN-1:0]    next_pc;
    logic [FLAGS_W-1:0] flags_out;
    logic               thumb_out;
    logic               error;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/arm_lba_shifter.sv @@
// Barrel shifter with carry-out: LSL, LSR, ASR, ROR and RRX.
// Depends on arm_lba_pkg.
`default_nettype none

module arm_lba_shifter (
  input  wire logic [arm_lba_pkg::XLEN-1:0] value_i,
  input  wire logic [2:0]                   kind_i,
  input  wire logic [5:0]                   amount_i,
  input  wire logic                         carry_i,
  output logic      [arm_lba_pkg::XLEN-1:0] value_o,
  output logic                              carry_o
);
  import arm_lba_pkg::*;

  logic [XLEN:0]          lsl_w;
  logic [XLEN:0]          lsr_w;
  logic signed [XLEN:0]   asr_w;
  logic [2*XLEN-1:0]      ror_w;

  assign lsl_w = {1'b0, value_i} << amount_i;
  assign lsr_w = {value_i, 1'b0} >> amount_i;
  assign asr_w = $signed({value_i, 1'b0}) >>> amount_i;
  assign ror_w = {value_i, value_i} >> amount_i[4:0];

  always_comb begin
    value_o = value_i;
    carry_o = carry_i;
    if (kind_i == SH_RRX) begin
      value_o = {carry_i, value_i[XLEN-1:1]};
      carry_o = value_i[0];
    end else if (amount_i != '0) begin
      case (kind_i)
        SH_LSR: begin
          value_o = lsr_w[XLEN:1];
          carry_o = lsr_w[0];
        end
        SH_ASR: begin
          value_o = asr_w[XLEN:1];
          carry_o = asr_w[0];
        end
        SH_ROR: begin
          value_o = ror_w[XLEN-1:0];
          carry_o = ror_w[XLEN-1];
        end
        default: begin
          value_o = lsl_w[XLEN-1:0];
          carry_o = lsl_w[XLEN];
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/arm_lba_exec.sv @@
// Execute logic: condition check, logical ops, BFC, extends, CLZ, PC writes.
// Depends on arm_lba_pkg and arm_lba_shifter.
`default_nettype none

module arm_lba_exec (
  input  wire arm_lba_pkg::item_t                      item_i,
  input  wire logic [arm_lba_pkg::FLAGS_W-1:0]         flags_i,
  input  wire logic                                    thumb_i,
  output arm_lba_pkg::result_t                         res_o
);
  import arm_lba_pkg::*;

  logic [XLEN-1:0] sh_val;
  logic            sh_carry;
  logic            cg_r;
  logic            pass;
  logic [XLEN-1:0] logic_r;
  logic [XLEN-1:0] rot;
  logic [XLEN-1:0] bfc_mask;
  logic [XLEN-1:0] rot_w;
  logic [2*XLEN-1:0] rot_x;
  logic [FLAGS_W-1:0] nzc_flags;

  function automatic logic [5:0] clz32(input logic [XLEN-1:0] x);
    logic [3:0] byte_cnt [4];
    logic [5:0] cnt;
    logic       found;
    for (int b = 0; b < 4; b++) begin
      byte_cnt[b] = 4'd8;
      for (int i = 0; i < 8; i++) begin
        if (x[8*b + i]) byte_cnt[b] = 4'(7 - i);
      end
    end
    cnt   = 6'd32;
    found = 1'b0;
    for (int b = 3; b >= 0; b--) begin
      if (!found && byte_cnt[b] != 4'd8) begin
        cnt   = 6'(8 * (3 - b)) + {2'b00, byte_cnt[b]};
        found = 1'b1;
      end
    end
    return cnt;
  endfunction

  arm_lba_shifter u_shifter (
    .value_i  (item_i.operand_value),
    .kind_i   (item_i.shift_kind),
    .amount_i (item_i.shift_amount),
    .carry_i  (item_i.carry_in),
    .value_o  (sh_val),
    .carry_o  (sh_carry)
  );

  always_comb begin
    unique case (item_i.cond[3:1])
      CG_EQ:   cg_r = flags_i[2];
      CG_CS:   cg_r = flags_i[1];
      CG_MI:   cg_r = flags_i[3];
      CG_VS:   cg_r = flags_i[0];
      CG_HI:   cg_r = flags_i[1] && !flags_i[2];
      CG_GE:   cg_r = (flags_i[3] == flags_i[0]);
      CG_GT:   cg_r = (flags_i[3] == flags_i[0]) && !flags_i[2];
      default: cg_r = 1'b1;
    endcase
  end

  assign pass = (item_i.cond[3:1] == CG_AL) ? 1'b1 : (item_i.cond[0] ? !cg_r : cg_r);

  always_comb begin
    unique case (item_i.opcode)
      OP_ORR:  logic_r = item_i.rn_value | sh_val;
      OP_EOR:  logic_r = item_i.rn_value ^ sh_val;
      OP_BIC:  logic_r = item_i.rn_value & ~sh_val;
      default: logic_r = item_i.rn_value & sh_val;
    endcase
  end

  assign nzc_flags = {logic_r[XLEN-1], logic_r == '0, sh_carry, flags_i[0]};

  assign rot_x = {item_i.operand_value, item_i.operand_value} >> item_i.shift_amount[4:0];
  assign rot_w = rot_x[XLEN-1:0];
  assign rot   = rot_w;

  always_comb begin
    for (int i = 0; i < XLEN; i++) begin
      bfc_mask[i] = (5'(i) >= item_i.field_lsb) && (5'(i) <= item_i.field_msb);
    end
  end

  always_comb begin
    res_o.executed     = 1'b0;
    res_o.result_value = '0;
    res_o.reg_write    = 1'b0;
    res_o.next_pc      = item_i.pc_value + PC_STEP;
    res_o.flags_out    = flags_i;
    res_o.thumb_out    = thumb_i;
    res_o.error        = 1'b0;
    if (pass) begin
      unique case (item_i.opcode)
        OP_TST: begin
          res_o.flags_out = nzc_flags;
          res_o.executed  = 1'b1;
        end
        OP_AND, OP_ORR, OP_EOR, OP_BIC: begin
          if (item_i.dest_is_pc) begin
            if (logic_r[0]) begin
              res_o.thumb_out    = 1'b1;
              res_o.next_pc      = {logic_r[XLEN-1:1], 1'b0};
              res_o.result_value = {logic_r[XLEN-1:1], 1'b0};
              res_o.executed     = 1'b1;
            end else if (!logic_r[1]) begin
              res_o.thumb_out    = 1'b0;
              res_o.next_pc      = logic_r;
              res_o.result_value = logic_r;
              res_o.executed     = 1'b1;
            end else begin
              res_o.error = 1'b1;
            end
          end else begin
            if (item_i.set_flags) res_o.flags_out = nzc_flags;
            res_o.result_value = logic_r;
            res_o.reg_write    = 1'b1;
            res_o.executed     = 1'b1;
          end
        end
        OP_BFC: begin
          if (item_i.field_msb >= item_i.field_lsb) begin
            res_o.result_value = item_i.rn_value & ~bfc_mask;
            res_o.reg_write    = 1'b1;
            res_o.executed     = 1'b1;
          end else begin
            res_o.error = 1'b1;
          end
        end
        OP_UXTB, OP_UXTH, OP_SXTB, OP_SXTH, OP_CLZ: begin
          unique case (item_i.opcode)
            OP_UXTB: res_o.result_value = rot & BYTE_MASK;
            OP_UXTH: res_o.result_value = rot & HALF_MASK;
            OP_SXTB: res_o.result_value = rot[7] ? (rot | (ALL_ONES & ~BYTE_MASK))
                                                 : (rot & BYTE_MASK);
            OP_SXTH: res_o.result_value = rot[15] ? (rot | (ALL_ONES & ~HALF_MASK))
                                                  : (rot & HALF_MASK);
            default: res_o.result_value = {26'd0, clz32(item_i.operand_value)};
          endcase
          res_o.reg_write = 1'b1;
          res_o.executed  = 1'b1;
        end
        default: begin
          res_o.executed = 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/arm_logical_bitfield_alu.sv @@
// Top level of the logical and bitfield execute unit: input register,
// execute logic and result register, with the NZCV and Thumb state.
// Depends on arm_lba_pkg and arm_lba_exec.
//
// Usage:
//   Requests arrive on the s_axis channel, one decoded ARM-state
//   instruction each; every request gives exactly one result on m_axis.
//   A request is taken into the input register; when the result register
//   can advance, the execute logic evaluates it against the current flags
//   and the result register captures it, raising m_axis_tvalid. Throughput
//   is one request per cycle while m_axis_tready is high, set by the single
//   flag feedback path from the result side back to the condition check.
//   NZCV and the Thumb bit update as each request moves into the result
//   register, so back-to-back requests see the flags of the one before.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more request; s_axis_tready then drops until
//   the result is taken.
//   Reset clears both valid stages, the flags (to zero) and the Thumb bit
//   (ARM state).
`default_nettype none

module arm_logical_bitfield_alu (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // opcode[3:0], cond[7:4], pc_value[39:8], rn_value[71:40],
  // operand_value[103:72], shift_kind[106:104], shift_amount[112:107],
  // carry_in[113], set_flags[114], dest_is_pc[115], field_msb[120:116],
  // field_lsb[125:121], zero fill[127:126]
  input  wire logic [arm_lba_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // executed[0], result_value[32:1], reg_write[33], next_pc[65:34],
  // flags_out[69:66], thumb_out[70], error[71]
  output logic      [arm_lba_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import arm_lba_pkg::*;

  item_t              item_d;
  item_t              item_q;
  logic               in_valid_q;
  result_t            res_d;
  result_t            res_q;
  logic               out_valid_q;
  logic [FLAGS_W-1:0] flags_q;
  logic               thumb_q;
  logic               adv;
  logic               in_take;

  assign item_d = '{
    opcode:        s_axis_tdata[3:0],
    cond:          s_axis_tdata[7:4],
    pc_value:      s_axis_tdata[39:8],
    rn_value:      s_axis_tdata[71:40],
    operand_value: s_axis_tdata[103:72],
    shift_kind:    s_axis_tdata[106:104],
    shift_amount:  s_axis_tdata[112:107],
    carry_in:      s_axis_tdata[113],
    set_flags:     s_axis_tdata[114],
    dest_is_pc:    s_axis_tdata[115],
    field_msb:     s_axis_tdata[120:116],
    field_lsb:     s_axis_tdata[125:121]
  };

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  arm_lba_exec u_exec (
    .item_i  (item_q),
    .flags_i (flags_q),
    .thumb_i (thumb_q),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
      thumb_q     <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (adv) begin
        out_valid_q <= 1'b1;
        flags_q     <= res_d.flags_out;
        thumb_q     <= res_d.thumb_out;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) item_q <= item_d;
    if (adv)     res_q  <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {res_q.error, res_q.thumb_out, res_q.flags_out, res_q.next_pc,
                          res_q.reg_write, res_q.result_value, res_q.executed};

`ifndef ASSERT_OFF
  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(flags_q) && $stable(thumb_q)))
    else $error("flags or thumb changed without a request advancing");

  a_out_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (res_q.flags_out == flags_q && res_q.thumb_out == thumb_q))
    else $error("result flags differ from stored state");

  a_err_not_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.error && res_q.executed))
    else $error("result marked both executed and error");

  a_write_needs_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.reg_write |-> res_q.executed)
    else $error("register write without execution");

  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q)
    else $error("input stage dropped a pending request");
`endif

endmodule

`default_nettype wire

@@ test/tb_arm_logical_bitfield_alu.sv @@
`timescale 1ns / 1ps
// Testbench for arm_logical_bitfield_alu: drives decoded logical/bitfield requests on s_axis,
// predicts each result with its own NZCV/Thumb tracking and checks m_axis field by field.
// Depends on arm_lba_pkg and the arm_logical_bitfield_alu RTL.

module tb_arm_logical_bitfield_alu;
  import arm_lba_pkg::*;

  localparam logic [3:0] COND_EQ    = 4'd0;
  localparam logic [3:0] COND_NE    = 4'd1;
  localparam logic [3:0] COND_AL    = 4'd14;
  localparam logic [3:0] COND_NV    = 4'd15;
  localparam logic [3:0] OP_UNDEF   = 4'd15;
  localparam logic [2:0] SH_UNDEF   = 3'd7;
  localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  logic [3:0]  nzcv_q  = '0;
  logic        thumb_q = 1'b0;
  result_t     pending_results[$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  bit          steady      = 1'b0;

  arm_logical_bitfield_alu dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [IN_DATA_W-1:0] pack_request(item_t it);
    return {2'b00, it.field_lsb, it.field_msb, it.dest_is_pc, it.set_flags, it.carry_in,
            it.shift_amount, it.shift_kind, it.operand_value, it.rn_value, it.pc_value,
            it.cond, it.opcode};
  endfunction

  function automatic logic cond_passes(logic [3:0] c, logic [3:0] f);
    logic r;
    case (cond_grp_e'(c[3:1]))
      CG_EQ:   r = f[2];
      CG_CS:   r = f[1];
      CG_MI:   r = f[3];
      CG_VS:   r = f[0];
      CG_HI:   r = f[1] && !f[2];
      CG_GE:   r = (f[3] == f[0]);
      CG_GT:   r = (f[3] == f[0]) && !f[2];
      default: return 1'b1;
    endcase
    return c[0] ? !r : r;
  endfunction

  function automatic logic [31:0] rotate_right(logic [31:0] x, logic [4:0] n);
    logic [63:0] both;
    both = {x, x} >> n;
    return both[31:0];
  endfunction

  function automatic logic [31:0] barrel_shift(input logic [31:0] x, input logic [2:0] kind,
                                               input logic [5:0] n, input logic cin,
                                               output logic cout);
    logic [31:0] r;
    if (kind == SH_RRX) begin
      cout = x[0];
      return {cin, x[31:1]};
    end
    if (n == 6'd0) begin
      cout = cin;
      return x;
    end
    case (kind)
      SH_LSR: begin
        if (n < 6'd32) begin
          cout = x[n - 1];
          return x >> n;
        end
        cout = (n == 6'd32) ? x[31] : 1'b0;
        return '0;
      end
      SH_ASR: begin
        if (n < 6'd32) begin
          cout = x[n - 1];
          return $signed(x) >>> n;
        end
        cout = x[31];
        return {32{x[31]}};
      end
      SH_ROR: begin
        r = rotate_right(x, n[4:0]);
        cout = r[31];
        return r;
      end
      default: begin
        if (n < 6'd32) begin
          cout = x[32 - n];
          return x << n;
        end
        cout = (n == 6'd32) ? x[0] : 1'b0;
        return '0;
      end
    endcase
  endfunction

  function automatic logic [31:0] leading_zeros(logic [31:0] x);
    logic [31:0] c;
    c = 0;
    while (c < 32 && !x[31]) begin
      x = x << 1;
      c++;
    end
    return c;
  endfunction

  function automatic void update_nzc(logic [31:0] r, logic c);
    nzcv_q = {r[31], r == 32'd0, c, nzcv_q[0]};
  endfunction

  function automatic result_t execute_instr(item_t it);
    result_t     res;
    logic [31:0] sh, r, rot;
    logic        cout;
    res = '0;
    res.next_pc = it.pc_value + PC_STEP;
    if (it.opcode <= OP_CLZ && cond_passes(it.cond, nzcv_q)) begin
      if (it.opcode <= OP_TST) begin
        sh = barrel_shift(it.operand_value, it.shift_kind, it.shift_amount, it.carry_in, cout);
        case (it.opcode)
          OP_ORR:  r = it.rn_value | sh;
          OP_EOR:  r = it.rn_value ^ sh;
          OP_BIC:  r = it.rn_value & ~sh;
          default: r = it.rn_value & sh;
        endcase
        if (it.opcode == OP_TST) begin
          update_nzc(r, cout);
          res.executed = 1'b1;
        end else if (it.dest_is_pc) begin
          if (r[0]) begin
            thumb_q = 1'b1;
            res.next_pc = {r[31:1], 1'b0};
            res.result_value = res.next_pc;
            res.executed = 1'b1;
          end else if (!r[1]) begin
            thumb_q = 1'b0;
            res.next_pc = r;
            res.result_value = r;
            res.executed = 1'b1;
          end else begin
            res.error = 1'b1;
          end
        end else begin
          if (it.set_flags) update_nzc(r, cout);
          res.result_value = r;
          res.reg_write = 1'b1;
          res.executed = 1'b1;
        end
      end else if (it.opcode == OP_BFC) begin
        if (it.field_msb >= it.field_lsb) begin
          res.result_value = it.rn_value &
                             ~((ALL_ONES >> (31 - it.field_msb)) & (ALL_ONES << it.field_lsb));
          res.reg_write = 1'b1;
          res.executed = 1'b1;
        end else begin
          res.error = 1'b1;
        end
      end else begin
        rot = rotate_right(it.operand_value, it.shift_amount[4:0]);
        case (it.opcode)
          OP_UXTB: res.result_value = rot & BYTE_MASK;
          OP_UXTH: res.result_value = rot & HALF_MASK;
          OP_SXTB: res.result_value = {{24{rot[7]}}, rot[7:0]};
          OP_SXTH: res.result_value = {{16{rot[15]}}, rot[15:0]};
          default: res.result_value = leading_zeros(it.operand_value);
        endcase
        res.reg_write = 1'b1;
        res.executed = 1'b1;
      end
    end
    res.flags_out = nzcv_q;
    res.thumb_out = thumb_q;
    return res;
  endfunction

  function automatic item_t make_item(logic [3:0] op, logic [3:0] cond, logic [31:0] rn,
                                      logic [31:0] opv, logic [2:0] sk, logic [5:0] sa,
                                      logic cin, logic sf, logic topc);
    item_t it;
    it.opcode        = op;
    it.cond          = cond;
    it.pc_value      = $urandom() & ~32'h3;
    it.rn_value      = rn;
    it.operand_value = opv;
    it.shift_kind    = sk;
    it.shift_amount  = sa;
    it.carry_in      = cin;
    it.set_flags     = sf;
    it.dest_is_pc    = topc;
    it.field_msb     = 5'd15;
    it.field_lsb     = 5'd8;
    return it;
  endfunction

  function automatic logic [31:0] random_word();
    case ($urandom_range(19))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return SIGN_BIT;
      default: return $urandom();
    endcase
  endfunction

  function automatic item_t random_instr();
    item_t       it;
    logic [4:0]  a, b;
    int unsigned pick;
    pick = $urandom_range(99);
    it.opcode = (pick < 3) ? 4'($urandom_range(15, 11)) : 4'($urandom_range(10, 0));
    it.cond = ($urandom_range(99) < 45) ? COND_AL : 4'($urandom_range(15));
    it.pc_value = $urandom();
    it.rn_value = random_word();
    it.operand_value = random_word();
    it.shift_kind = ($urandom_range(99) < 5) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
    pick = $urandom_range(99);
    if (it.opcode >= OP_UXTB && it.opcode <= OP_SXTH && pick < 70)
      it.shift_amount = 6'($urandom_range(3) * 8);
    else if (pick < 10)
      it.shift_amount = 6'($urandom_range(63, 33));
    else if (pick < 20)
      it.shift_amount = ($urandom_range(1)) ? 6'd32 : 6'd0;
    else
      it.shift_amount = 6'($urandom_range(31));
    it.carry_in = 1'($urandom_range(1));
    it.set_flags = 1'($urandom_range(1));
    it.dest_is_pc = ($urandom_range(99) < 15);
    a = 5'($urandom_range(31));
    b = 5'($urandom_range(31));
    if ($urandom_range(99) < 75 && a < b) begin
      it.field_msb = b;
      it.field_lsb = a;
    end else begin
      it.field_msb = a;
      it.field_lsb = b;
    end
    return it;
  endfunction

  task automatic send_request(input item_t it);
    while (!steady && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_request(it);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(execute_instr(it));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 11);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_arm_logical_bitfield_alu NOT OK");
      $finish;
    end
  end

  function automatic void match_field(string name, logic [31:0] want, logic [31:0] seen);
    if (want !== seen) begin
      $error("%s: expected %h, got %h", name, want, seen);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        match_field("executed", 32'(want.executed), 32'(m_axis_tdata[0]));
        match_field("result_value", want.result_value, m_axis_tdata[32:1]);
        match_field("reg_write", 32'(want.reg_write), 32'(m_axis_tdata[33]));
        match_field("next_pc", want.next_pc, m_axis_tdata[65:34]);
        match_field("flags_out", 32'(want.flags_out), 32'(m_axis_tdata[69:66]));
        match_field("thumb_out", 32'(want.thumb_out), 32'(m_axis_tdata[70]));
        match_field("error", 32'(want.error), 32'(m_axis_tdata[71]));
      end
    end
  end

  task automatic test_directed();
    item_t it;
    send_request(make_item(OP_AND, COND_AL, ALL_ONES, ALL_ONES, SH_LSL, 6'd0, 1'b1, 1'b1, 1'b0));
    send_request(make_item(OP_ORR, COND_AL, '0, '0, SH_LSL, 6'd0, 1'b0, 1'b1, 1'b0));
    send_request(make_item(OP_EOR, COND_AL, 32'h1234_5678, SIGN_BIT, SH_LSR, 6'd32,
                           1'b0, 1'b1, 1'b0));
    send_request(make_item(OP_BIC, COND_AL, ALL_ONES, SIGN_BIT, SH_ASR, 6'd40, 1'b0, 1'b1, 1'b0));
    send_request(make_item(OP_TST, COND_AL, ALL_ONES, SIGN_BIT, SH_ROR, 6'd32, 1'b0, 1'b0, 1'b1));
    send_request(make_item(OP_TST, COND_AL, ALL_ONES, 32'h0000_0003, SH_RRX, 6'd63, 1'b1, 1'b0,
                           1'b0));
    send_request(make_item(OP_AND, COND_AL, ALL_ONES, ALL_ONES, SH_LSL, 6'd33, 1'b1, 1'b1, 1'b0));
    send_request(make_item(OP_AND, COND_EQ, ALL_ONES, 32'h00F0_000F, SH_LSL, 6'd4, 1'b0, 1'b1,
                           1'b0));
    send_request(make_item(OP_ORR, COND_AL, '0, 32'h0000_8001, SH_LSL, 6'd0, 1'b0, 1'b1, 1'b1));
    send_request(make_item(OP_EOR, COND_AL, '0, 32'h0001_0000, SH_LSL, 6'd0, 1'b0, 1'b1, 1'b1));
    send_request(make_item(OP_AND, COND_AL, ALL_ONES, 32'h0000_0102, SH_LSL, 6'd0, 1'b0, 1'b0,
                           1'b1));
    send_request(make_item(OP_BIC, COND_NE, ALL_ONES, 32'h0000_0003, SH_LSL, 6'd0, 1'b0, 1'b1,
                           1'b1));
    it = make_item(OP_BFC, COND_AL, ALL_ONES, '0, SH_LSL, 6'd0, 1'b0, 1'b0, 1'b0);
    it.field_msb = 5'd31;
    it.field_lsb = 5'd0;
    send_request(it);
    it.field_msb = 5'd3;
    it.field_lsb = 5'd7;
    send_request(it);
    it.field_msb = 5'd31;
    it.field_lsb = 5'd31;
    it.dest_is_pc = 1'b1;
    send_request(it);
    send_request(make_item(OP_UXTB, COND_AL, '0, 32'h0000_AB00, SH_LSL, 6'd8, 1'b0, 1'b0, 1'b1));
    send_request(make_item(OP_UXTH, COND_AL, '0, 32'hCDEF_0000, SH_LSL, 6'd16, 1'b0, 1'b0, 1'b0));
    send_request(make_item(OP_SXTB, COND_AL, '0, 32'h8000_0000, SH_LSL, 6'd24, 1'b0, 1'b0, 1'b0));
    send_request(make_item(OP_SXTH, COND_AL, '0, 32'h0080_0000, SH_LSL, 6'd40, 1'b0, 1'b0, 1'b0));
    send_request(make_item(OP_CLZ, COND_AL, '0, '0, SH_LSL, 6'd0, 1'b0, 1'b0, 1'b0));
    send_request(make_item(OP_CLZ, COND_NV, '0, SIGN_BIT, SH_LSL, 6'd0, 1'b0, 1'b0, 1'b1));
    send_request(make_item(OP_UNDEF, COND_AL, ALL_ONES, ALL_ONES, SH_LSL, 6'd0, 1'b1, 1'b1, 1'b0));
    send_request(make_item(OP_ORR, COND_AL, '0, 32'h4000_0001, SH_UNDEF, 6'd1, 1'b0, 1'b1, 1'b0));
    send_request(make_item(OP_EOR, COND_AL, ALL_ONES, 32'h0000_0001, SH_LSR, 6'd63, 1'b1, 1'b1,
                           1'b0));
  endtask

  task automatic test_steady_burst();
    steady = 1'b1;
    repeat (200) send_request(random_instr());
    steady = 1'b0;
  endtask

  task automatic test_pause_until_drained();
    repeat (60) send_request(random_instr());
    drain_results();
    repeat (60) send_request(random_instr());
  endtask

  task automatic test_random_mix();
    repeat (1206) send_request(random_instr());
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_steady_burst();
    test_pause_until_drained();
    test_random_mix();
    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_arm_logical_bitfield_alu OK");
    end else begin
      $display("tb_arm_logical_bitfield_alu NOT OK");
    end
    $finish;
  end

endmodule
